[rtl/gtp_pkg.sv]
// Shared types and constants for the go-to-point drive command block.
// Used by gtp_ctrl, gtp_dpath and go_to_point_drive_command.
package gtp_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int SQRT_STEPS   = 17;
    localparam int ITER_N       = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;
    localparam int DIV_BITS     = 26;
    localparam int CNT_W        = 5;

    localparam logic [13:0]        K_SCALE   = 14'd11356;
    localparam logic signed [35:0] PI_Q30    = 36'sd3373259426;
    localparam logic signed [35:0] TWO_PI_Q30 = 36'sd6746518852;

    // configuration register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_DGAIN  = 2'd2;
    localparam logic [1:0] REG_TGAIN  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_DIVX_LD, S_DIVX, S_DIVY_LD, S_DIVY, S_DIFF,
        S_SETUP, S_ITER, S_WRAP, S_ROUND, S_SCALE, S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_DIVX_LD, OP_DIV_STEP, OP_DIVY_LD, OP_DIFF,
        OP_SETUP, OP_ITER, OP_WRAP, OP_ROUND, OP_SCALE, OP_PUBLISH
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [CNT_W-1:0] step;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

    // arctangent of 2^-i in units of 2^-30 rad
    function automatic logic signed [35:0] atan_q30(input logic [CNT_W-1:0] i);
        logic signed [35:0] v;
        begin
            case (i)
                5'd0:  v = 36'sh03243F6A8;
                5'd1:  v = 36'sh01DAC6705;
                5'd2:  v = 36'sh00FADBAFC;
                5'd3:  v = 36'sh007F56EA6;
                5'd4:  v = 36'sh003FEAB76;
                5'd5:  v = 36'sh001FFD55B;
                5'd6:  v = 36'sh000FFFAAA;
                5'd7:  v = 36'sh0007FFF55;
                5'd8:  v = 36'sh0003FFFEA;
                5'd9:  v = 36'sh0001FFFFD;
                5'd10: v = 36'sh0000FFFFF;
                5'd11: v = 36'sh00007FFFF;
                5'd12: v = 36'sh00003FFFF;
                5'd13: v = 36'sh00001FFFF;
                5'd14: v = 36'sh00000FFFF;
                5'd15: v = 36'sh000007FFF;
                5'd16: v = 36'sh000003FFF;
                5'd17: v = 36'sh000001FFF;
                5'd18: v = 36'sh000000FFF;
                5'd19: v = 36'sh0000007FF;
                5'd20: v = 36'sh0000003FF;
                5'd21: v = 36'sh0000001FF;
                5'd22: v = 36'sh0000000FF;
                5'd23: v = 36'sh00000007F;
                default: v = 36'sd0;
            endcase
            return v;
        end
    endfunction

endpackage

[rtl/gtp_ctrl.sv]
// Sequencer for the go-to-point block: steps the datapath through
// divide, CORDIC/square-root and scaling phases. Depends on gtp_pkg.
module gtp_ctrl import gtp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_action,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // state and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state and datapath command
    always_comb begin
        n_state    = r_state;
        n_cnt      = '0;
        o_cmd.op   = OP_NONE;
        o_cmd.step = r_cnt;
        o_in_stall = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    if (i_in_action) n_state = S_DIVX_LD;
                end
            end
            S_DIVX_LD: begin
                o_cmd.op = OP_DIVX_LD;
                n_state  = S_DIVX;
            end
            S_DIVX: begin
                o_cmd.op = OP_DIV_STEP;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_BITS - 1)) begin
                    n_state = S_DIVY_LD;
                    n_cnt   = '0;
                end
            end
            S_DIVY_LD: begin
                o_cmd.op = OP_DIVY_LD;
                n_state  = S_DIVY;
            end
            S_DIVY: begin
                o_cmd.op = OP_DIV_STEP;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_BITS - 1)) begin
                    n_state = S_DIFF;
                    n_cnt   = '0;
                end
            end
            S_DIFF: begin
                o_cmd.op = OP_DIFF;
                n_state  = S_SETUP;
            end
            S_SETUP: begin
                o_cmd.op = OP_SETUP;
                n_state  = S_ITER;
            end
            S_ITER: begin
                o_cmd.op = OP_ITER;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ITER_N - 1)) begin
                    n_state = S_WRAP;
                    n_cnt   = '0;
                end
            end
            S_WRAP: begin
                o_cmd.op = OP_WRAP;
                n_state  = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.op = OP_ROUND;
                n_state  = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.op = OP_SCALE;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_PUBLISH;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // a target request starts the divide phase, a pose request does not
    a_target_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid && i_in_action) |=> r_state == S_DIVX_LD)
        else $error("target request did not start the divide");
    a_pose_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid && !i_in_action) |=> r_state == S_IDLE)
        else $error("pose request left idle");
    a_div_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVX || r_state == S_DIVY) |-> r_cnt < CNT_W'(DIV_BITS))
        else $error("divide counter overran");

endmodule

[rtl/gtp_dpath.sv]
// Datapath for the go-to-point block: config registers, pose store, shared
// divider, CORDIC vectoring, square root, gains and output register. Uses gtp_pkg.
module gtp_dpath import gtp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_action,
    input  logic signed [15:0] i_pose_x,
    input  logic signed [15:0] i_pose_y,
    input  logic signed [14:0] i_pose_heading,
    input  logic [11:0]        i_obj_col,
    input  logic [11:0]        i_obj_row,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [15:0]        o_linear_speed,
    output logic signed [15:0] o_angular_speed,
    output logic signed [14:0] o_heading_error
);

    logic [11:0] r_w, r_h;
    logic [15:0] r_dg, r_tg;
    logic signed [15:0] r_pos_x, r_pos_y, r_head;
    logic [11:0] r_col, r_row;
    logic [DIV_BITS-1:0] r_q;
    logic [12:0] r_rem;
    logic [11:0] r_div;
    logic signed [15:0] r_tx;
    logic signed [16:0] r_dx, r_dy;
    logic signed [27:0] r_cx, r_cy;
    logic signed [35:0] r_cz, r_err;
    logic r_zero;
    logic [33:0] r_n, r_r, r_bit;
    logic signed [14:0] r_errq;
    logic [33:0] r_sprod;
    logic signed [31:0] r_tprod;
    logic r_out_valid;
    logic [15:0] r_speed;
    logic signed [15:0] r_ang;
    logic signed [14:0] r_herr;

    logic [11:0] w_eff, h_eff;
    logic [12:0] div_t;
    logic        div_ge;
    logic signed [15:0] tx_sat, ty_sat;
    logic signed [27:0] ty_full;
    logic signed [33:0] sq_x, sq_y;
    logic signed [27:0] x0, y0, xs, ys;
    logic signed [35:0] e0, e1, e2, z_eff;
    logic [33:0] sq_t;
    logic signed [35:0] e_rnd;
    logic [34:0] sp_sum;
    logic signed [32:0] t_sum;
    logic signed [20:0] t_shr;

    assign w_eff = (r_w == 12'd0) ? 12'd1 : r_w;
    assign h_eff = (r_h == 12'd0) ? 12'd1 : r_h;

    // restoring divide step, one quotient bit a cycle
    assign div_t  = {r_rem[11:0], r_q[DIV_BITS-1]};
    assign div_ge = (div_t >= {1'b0, r_div});

    // saturate mapped target coordinates
    assign tx_sat  = (r_q > DIV_BITS'(32767)) ? 16'sd32767 : $signed(r_q[15:0]);
    assign ty_full = 28'sd11356 - $signed({2'b00, r_q});
    assign ty_sat  = (ty_full < -28'sd32768) ? -16'sd32768 : ty_full[15:0];

    // squares and CORDIC start vector
    assign sq_x = r_dx * r_dx;
    assign sq_y = r_dy * r_dy;
    assign x0   = {{3{r_dx[16]}}, r_dx, 8'd0};
    assign y0   = {{3{r_dy[16]}}, r_dy, 8'd0};
    assign xs   = r_cx >>> i_cmd.step;
    assign ys   = r_cy >>> i_cmd.step;
    assign sq_t = r_r + r_bit;

    // heading error, wrapped once each way
    assign z_eff = r_zero ? 36'sd0 : r_cz;
    assign e0    = z_eff - ({{20{r_head[15]}}, r_head} <<< 18);
    assign e1    = (e0 > PI_Q30) ? e0 - TWO_PI_Q30 : e0;
    assign e2    = (e1 <= -PI_Q30) ? e1 + TWO_PI_Q30 : e1;
    assign e_rnd = r_err + 36'sd131072;

    // gain rounding
    assign sp_sum = {1'b0, r_sprod} + 35'd2048;
    assign t_sum  = {r_tprod[31], r_tprod} + 33'sd2048;
    assign t_shr  = t_sum[32:12];

    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w  <= 12'd640;
            r_h  <= 12'd480;
            r_dg <= 16'd1024;
            r_tg <= 16'd3072;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WIDTH:  r_w  <= i_cfg_data[11:0];
                REG_HEIGHT: r_h  <= i_cfg_data[11:0];
                REG_DGAIN:  r_dg <= i_cfg_data;
                REG_TGAIN:  r_tg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pose store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_head  <= '0;
        end else if (i_cmd.op == OP_LOAD && !i_action) begin
            r_pos_x <= i_pose_x;
            r_pos_y <= i_pose_y;
            r_head  <= {i_pose_heading[14], i_pose_heading};
        end
    end

    // arithmetic sequence
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_col <= i_obj_col;
                r_row <= i_obj_row;
            end
            OP_DIVX_LD: begin
                r_q   <= DIV_BITS'(K_SCALE) * DIV_BITS'(r_col) + DIV_BITS'(w_eff >> 1);
                r_rem <= '0;
                r_div <= w_eff;
            end
            OP_DIV_STEP: begin
                r_rem <= div_ge ? div_t - {1'b0, r_div} : div_t;
                r_q   <= {r_q[DIV_BITS-2:0], div_ge};
            end
            OP_DIVY_LD: begin
                r_tx  <= tx_sat;
                r_q   <= DIV_BITS'(K_SCALE) * DIV_BITS'(r_row) + DIV_BITS'(h_eff >> 1);
                r_rem <= '0;
                r_div <= h_eff;
            end
            OP_DIFF: begin
                r_dx <= {r_tx[15], r_tx} - {r_pos_x[15], r_pos_x};
                r_dy <= {ty_sat[15], ty_sat} - {r_pos_y[15], r_pos_y};
            end
            OP_SETUP: begin
                r_n    <= 34'(sq_x) + 34'(sq_y);
                r_r    <= '0;
                r_bit  <= 34'd1 << 32;
                r_zero <= (r_dx == 17'sd0) && (r_dy == 17'sd0);
                if (r_dx < 17'sd0) begin
                    r_cx <= -x0;
                    r_cy <= -y0;
                    r_cz <= (r_dy >= 17'sd0) ? PI_Q30 : -PI_Q30;
                end else begin
                    r_cx <= x0;
                    r_cy <= y0;
                    r_cz <= '0;
                end
            end
            OP_ITER: begin
                if (i_cmd.step < CNT_W'(CORDIC_STEPS)) begin
                    if (r_cy > 28'sd0) begin
                        r_cx <= r_cx + ys;
                        r_cy <= r_cy - xs;
                        r_cz <= r_cz + atan_q30(i_cmd.step);
                    end else begin
                        r_cx <= r_cx - ys;
                        r_cy <= r_cy + xs;
                        r_cz <= r_cz - atan_q30(i_cmd.step);
                    end
                end
                if (i_cmd.step < CNT_W'(SQRT_STEPS)) begin
                    if (r_n >= sq_t) begin
                        r_n <= r_n - sq_t;
                        r_r <= (r_r >> 1) + r_bit;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end
            end
            OP_WRAP: r_err <= e2;
            OP_ROUND: begin
                r_errq  <= e_rnd[32:18];
                r_sprod <= r_dg * r_r[17:0];
            end
            OP_SCALE: r_tprod <= $signed({1'b0, r_tg}) * r_errq;
            OP_PUBLISH: begin
                r_speed <= (sp_sum[34:12] > 23'd65535) ? 16'hFFFF : sp_sum[27:12];
                r_herr  <= r_errq;
                if (t_shr > 21'sd32767)       r_ang <= 16'sd32767;
                else if (t_shr < -21'sd32768) r_ang <= -16'sd32768;
                else                          r_ang <= t_shr[15:0];
            end
            default: ;
        endcase
    end

    // output request valid: set on publish, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_PUBLISH) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_linear_speed  = r_speed;
    assign o_angular_speed = r_ang;
    assign o_heading_error = r_herr;

    // wrapped error lies in (-pi, pi]
    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_ROUND) |-> (r_err <= PI_Q30 && r_err > -PI_Q30))
        else $error("heading error outside wrap range");
    a_publish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_PUBLISH) |-> (!r_out_valid || !i_out_stall))
        else $error("publish over a pending result");
    a_sqrt_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_ITER) |-> $countones(r_bit) <= 1)
        else $error("square root bit lost one-hot form");

endmodule

[rtl/go_to_point_drive_command.sv]
// Top level of the go-to-point drive command block.
// Joins gtp_ctrl and gtp_dpath; depends on gtp_pkg.
//
// A pose request (action 0) stores x, y and heading when accepted and gives no
// result. A target request (action 1) runs from acceptance to the result
// register through two 26-step restoring divides for the pixel-to-world
// mapping, a 17-step phase that runs the CORDIC vectoring unit and the
// square root side by side, and the wrap, rounding and gain multiply
// steps. One request is processed at a time; the result register lets a
// new request enter while the previous result waits to be taken. Config
// writes are always ready and must be issued only while the block is idle.
module go_to_point_drive_command import gtp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_action,
    input  logic signed [15:0] i_pose_x,
    input  logic signed [15:0] i_pose_y,
    input  logic signed [14:0] i_pose_heading,
    input  logic [11:0]        i_obj_col,
    input  logic [11:0]        i_obj_row,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [15:0]        o_linear_speed,
    output logic signed [15:0] o_angular_speed,
    output logic signed [14:0] o_heading_error
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    gtp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_action (i_action),
        .o_in_stall  (o_in_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    gtp_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_valid & o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_action        (i_action),
        .i_pose_x        (i_pose_x),
        .i_pose_y        (i_pose_y),
        .i_pose_heading  (i_pose_heading),
        .i_obj_col       (i_obj_col),
        .i_obj_row       (i_obj_row),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_linear_speed  (o_linear_speed),
        .o_angular_speed (o_angular_speed),
        .o_heading_error (o_heading_error)
    );

endmodule
